### hdl/ucf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ucf_pkg;

    localparam int MODEL_BITS = 12;
    localparam int SCENE_BITS = 16;
    localparam int DIST_BITS  = 32;
    localparam int KIND_BITS  = 2;

    localparam int DEF_MODEL_POINTS     = 4096;
    localparam int DEF_SCENE_INDEX_BITS = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_KEPT   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_EMPTY  = 2'd2;

    typedef struct packed {
        logic                  op;
        logic [MODEL_BITS-1:0] model_index;
        logic [SCENE_BITS-1:0] scene_index;
        logic [DIST_BITS-1:0]  dist_sqr;
    } t_in_item;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [MODEL_BITS-1:0] out_model;
        logic [SCENE_BITS-1:0] out_scene;
        logic [DIST_BITS-1:0]  out_dist;
        logic                  last;
    } t_out_item;

endpackage

`default_nettype wire

### hdl/ucf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ucf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/ucf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ucf_ctrl
    import ucf_pkg::*;
#(
    parameter int MODEL_POINTS     = DEF_MODEL_POINTS,
    parameter int SCENE_INDEX_BITS = DEF_SCENE_INDEX_BITS,
    localparam int AW = $clog2(MODEL_POINTS),
    localparam int SW = (SCENE_INDEX_BITS < SCENE_BITS) ? SCENE_INDEX_BITS : SCENE_BITS,
    localparam int DW = 1 + SW + DIST_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_enable,
    input  wire logic          start,
    output logic               busy,
    input  wire t_in_item      i_item,
    output logic               o_strobe,
    output t_out_item          o_result,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [DW-1:0]      o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  wire logic [DW-1:0] i_ram_rdata
);

    localparam int PW = $clog2(MODEL_POINTS + 1);
    localparam logic [PW-1:0] PTR_END  = PW'(MODEL_POINTS);
    localparam logic [AW-1:0] ADDR_TOP = AW'(MODEL_POINTS - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [AW-1:0]        r_scan, n_scan;
    logic [PW-1:0]        r_ptr, n_ptr;
    logic [PW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_addr, n_addr;
    logic [SW-1:0]        r_scene, n_scene;
    logic [DIST_BITS-1:0] r_dist, n_dist;
    logic                 r_strobe, n_strobe;
    t_out_item            r_res, n_res;

    logic [31:0]           w_model_ext;
    logic [31:0]           w_scene_ext;
    logic [SW-1:0]         w_scene_in;
    logic [31:0]           w_scene_in_ext;
    logic                  w_in_range;
    logic                  w_slot_valid;
    logic [SW-1:0]         w_slot_scene;
    logic [DIST_BITS-1:0]  w_slot_dist;
    logic [31:0]           w_slot_scene_ext;
    logic [31:0]           w_scan_ext;
    logic [31:0]           w_r_scene_ext;
    logic [PW-1:0]         w_count_dec;

    assign w_model_ext    = 32'(i_item.model_index);
    assign w_scene_ext    = 32'(i_item.scene_index);
    assign w_scene_in     = w_scene_ext[SW-1:0];
    assign w_scene_in_ext = 32'(w_scene_in);
    assign w_in_range     = w_model_ext < 32'(MODEL_POINTS);

    assign {w_slot_valid, w_slot_scene, w_slot_dist} = i_ram_rdata;
    assign w_slot_scene_ext = 32'(w_slot_scene);
    assign w_scan_ext       = 32'(r_scan);
    assign w_r_scene_ext    = 32'(r_scene);
    assign w_count_dec      = (r_count != '0) ? r_count - PW'(1) : r_count;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_scan   = r_scan;
        n_ptr    = r_ptr;
        n_count  = r_count;
        n_addr   = r_addr;
        n_scene  = r_scene;
        n_dist   = r_dist;
        n_strobe = 1'b0;
        n_res    = r_res;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr;
        o_ram_wdata = {1'b1, r_scene, r_dist};
        o_ram_raddr = r_ptr[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr;
                o_ram_wdata = '0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == ADDR_TOP) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item.op == OP_LOAD) begin
                    o_ram_raddr = w_model_ext[AW-1:0];
                end
                if (start) begin
                    if (i_item.op == OP_LOAD) begin
                        n_addr  = w_model_ext[AW-1:0];
                        n_scene = w_scene_in;
                        n_dist  = i_item.dist_sqr;
                        if (!i_enable) begin
                            // filter off: pass the pair straight through
                            n_strobe        = 1'b1;
                            n_res.kind      = KIND_KEPT;
                            n_res.out_model = i_item.model_index;
                            n_res.out_scene = w_scene_in_ext[SCENE_BITS-1:0];
                            n_res.out_dist  = i_item.dist_sqr;
                            n_res.last      = 1'b0;
                        end else if (!w_in_range) begin
                            n_strobe        = 1'b1;
                            n_res.kind      = KIND_REJECT;
                            n_res.out_model = '0;
                            n_res.out_scene = w_scene_in_ext[SCENE_BITS-1:0];
                            n_res.out_dist  = '0;
                            n_res.last      = 1'b0;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        if (r_ptr == PTR_END) begin
                            n_strobe = 1'b1;
                            n_res    = '{kind: KIND_EMPTY, default: '0};
                            n_ptr    = '0;
                        end else begin
                            n_scan  = r_ptr[AW-1:0];
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
                if (!w_slot_valid) begin
                    o_ram_we = 1'b1;
                    n_count  = r_count + PW'(1);
                end else if (r_dist < w_slot_dist) begin
                    // new pair wins, the displaced scene point is rejected
                    o_ram_we        = 1'b1;
                    n_strobe        = 1'b1;
                    n_res.kind      = KIND_REJECT;
                    n_res.out_model = '0;
                    n_res.out_scene = w_slot_scene_ext[SCENE_BITS-1:0];
                    n_res.out_dist  = '0;
                    n_res.last      = 1'b0;
                end else begin
                    n_strobe        = 1'b1;
                    n_res.kind      = KIND_REJECT;
                    n_res.out_model = '0;
                    n_res.out_scene = w_r_scene_ext[SCENE_BITS-1:0];
                    n_res.out_dist  = '0;
                    n_res.last      = 1'b0;
                end
            end
            S_SCAN: begin
                // read of the next slot overlaps the check of this one
                o_ram_raddr = r_scan + AW'(1);
                if (w_slot_valid) begin
                    o_ram_we        = 1'b1;
                    o_ram_waddr     = r_scan;
                    o_ram_wdata     = '0;
                    n_count         = w_count_dec;
                    n_ptr           = PW'(r_scan) + PW'(1);
                    n_strobe        = 1'b1;
                    n_res.kind      = KIND_KEPT;
                    n_res.out_model = w_scan_ext[MODEL_BITS-1:0];
                    n_res.out_scene = w_slot_scene_ext[SCENE_BITS-1:0];
                    n_res.out_dist  = w_slot_dist;
                    n_res.last      = (w_count_dec == '0);
                    n_state         = S_IDLE;
                end else if (r_scan == ADDR_TOP) begin
                    n_strobe = 1'b1;
                    n_res    = '{kind: KIND_EMPTY, default: '0};
                    n_ptr    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_scan = r_scan + AW'(1);
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_scan   <= '0;
            r_ptr    <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_scan   <= n_scan;
            r_ptr    <= n_ptr;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_scene <= n_scene;
        r_dist  <= n_dist;
        r_res   <= n_res;
    end

endmodule

`default_nettype wire

### hdl/unique_correspondence_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// unique correspondence filter: keeps the nearest scene point per model point
// input channel: an item is taken on a rising edge with start high and busy low
//   op load brings model index, scene index and squared distance (q16.16)
//   op drain asks for the next kept pair in ascending model index
// result channel: o_strobe marks o_result for exactly one cycle, the
//   receiver cannot stall, so every result leaves on the cycle it is shown
// load: one read-modify-write of the slot memory in S_LOAD with busy high; the
//   strobe is registered from S_LOAD, none for an empty slot; a disabled load or
//   an out-of-range model index answers in the next cycle, busy stays low
// drain: scans the slot memory one entry a cycle from the drain pointer until a
//   held slot or the top slot is reached, then answers; the scan speed is set
//   by the single memory read port
// reset: a clearing pass writes every slot invalid with busy high, enable returns
//   to 1; enable is to be written through i_cfg_we / i_cfg_wdata only while the
//   block is idle, and the block itself does not enforce that

module unique_correspondence_filter
    import ucf_pkg::*;
#(
    parameter int MODEL_POINTS     = DEF_MODEL_POINTS,
    parameter int SCENE_INDEX_BITS = DEF_SCENE_INDEX_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    output logic          o_strobe,
    output t_out_item     o_result
);

    // slot word: valid flag, stored scene index, stored squared distance
    localparam int AW = $clog2(MODEL_POINTS);
    localparam int SW = (SCENE_INDEX_BITS < SCENE_BITS) ? SCENE_INDEX_BITS : SCENE_BITS;
    localparam int DW = 1 + SW + DIST_BITS;

    // filter enable, resets to on
    logic r_enable;

    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [DW-1:0] w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic [DW-1:0] w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // sequencer: clearing pass, load read-modify-write and drain scan
    ucf_ctrl #(
        .MODEL_POINTS     (MODEL_POINTS),
        .SCENE_INDEX_BITS (SCENE_INDEX_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    // slot table, one word per model point, registered read
    ucf_ram #(
        .WIDTH (DW),
        .DEPTH (MODEL_POINTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

`default_nettype wire

### verif/ucf_pair_checker.sv
`timescale 1ns / 1ps

module ucf_pair_checker
    import ucf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata,
    input  wire logic      i_start,
    input  wire logic      i_busy,
    input  wire t_in_item  i_item,
    input  wire logic      i_strobe,
    input  wire t_out_item i_result,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int MODEL_POINTS = DEF_MODEL_POINTS;

    // shadow of the slot table and drain state
    logic                  filter_on;
    bit                    slot_held  [MODEL_POINTS];
    logic [SCENE_BITS-1:0] held_scene [MODEL_POINTS];
    logic [DIST_BITS-1:0]  held_dist  [MODEL_POINTS];
    int unsigned           scan_ptr;
    int unsigned           held_count;

    t_out_item             awaited_answers [$];

    task automatic clear_table();
        filter_on  = 1'b1;
        scan_ptr   = 0;
        held_count = 0;
        for (int i = 0; i < MODEL_POINTS; i++) begin
            slot_held[i] = 1'b0;
        end
        awaited_answers.delete();
    endtask

    // appends one expected answer at the tail
    task automatic queue_answer(input t_out_item ans);
        awaited_answers.insert(awaited_answers.size(), ans);
    endtask

    // works out the answer, if any, that one accepted item causes
    task automatic filter_pair(input t_in_item it);
        t_out_item   ans;
        int unsigned idx;
        ans = '0;
        if (it.op == OP_LOAD) begin
            if (!filter_on) begin
                ans.kind      = KIND_KEPT;
                ans.out_model = it.model_index;
                ans.out_scene = it.scene_index;
                ans.out_dist  = it.dist_sqr;
                queue_answer(ans);
            end else if (!slot_held[it.model_index]) begin
                slot_held[it.model_index]  = 1'b1;
                held_scene[it.model_index] = it.scene_index;
                held_dist[it.model_index]  = it.dist_sqr;
                held_count++;
            end else if (it.dist_sqr < held_dist[it.model_index]) begin
                // nearer pair displaces the stored one
                ans.kind  = KIND_REJECT;
                ans.out_scene = held_scene[it.model_index];
                held_scene[it.model_index] = it.scene_index;
                held_dist[it.model_index]  = it.dist_sqr;
                queue_answer(ans);
            end else begin
                // ties keep the earlier pair
                ans.kind      = KIND_REJECT;
                ans.out_scene = it.scene_index;
                queue_answer(ans);
            end
        end else begin
            idx = scan_ptr;
            while (idx < MODEL_POINTS && !slot_held[idx]) begin
                idx++;
            end
            if (idx >= MODEL_POINTS) begin
                scan_ptr = 0;
                ans.kind = KIND_EMPTY;
            end else begin
                slot_held[idx] = 1'b0;
                if (held_count > 0) begin
                    held_count--;
                end
                scan_ptr      = idx + 1;
                ans.kind      = KIND_KEPT;
                ans.out_model = idx[MODEL_BITS-1:0];
                ans.out_scene = held_scene[idx];
                ans.out_dist  = held_dist[idx];
                ans.last      = (held_count == 0);
            end
            queue_answer(ans);
        end
    endtask

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endtask

    task automatic compare_answer(input t_out_item got);
        t_out_item want;
        bit        bad;
        bad = 1'b0;
        if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            o_fail_count++;
        end else begin
            want = awaited_answers.pop_front();
            if (got.kind !== want.kind) begin
                flag_field("kind", 32'(want.kind), 32'(got.kind));
                bad = 1'b1;
            end
            if (got.out_model !== want.out_model) begin
                flag_field("out_model", 32'(want.out_model), 32'(got.out_model));
                bad = 1'b1;
            end
            if (got.out_scene !== want.out_scene) begin
                flag_field("out_scene", 32'(want.out_scene), 32'(got.out_scene));
                bad = 1'b1;
            end
            if (got.out_dist !== want.out_dist) begin
                flag_field("out_dist", want.out_dist, got.out_dist);
                bad = 1'b1;
            end
            if (got.last !== want.last) begin
                flag_field("last", 32'(want.last), 32'(got.last));
                bad = 1'b1;
            end
            if (bad) begin
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            o_fail_count = 0;
        end else begin
            // answers leaving now belong to items taken at earlier edges
            if (i_strobe === 1'b1) begin
                compare_answer(i_result);
            end
            if (i_start && !i_busy) begin
                filter_pair(i_item);
            end
            if (i_cfg_we) begin
                filter_on = i_cfg_wdata;
            end
        end
        o_pending <= awaited_answers.size();
    end

endmodule

### verif/unique_correspondence_filter_test.sv
`timescale 1ns / 1ps

module unique_correspondence_filter_test;
    import ucf_pkg::*;

    // longest quiet stretch: clearing pass or a full drain scan, well covered
    localparam int IDLE_LIMIT  = 20000;
    localparam int ITEM_TARGET = 1150;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      start;
    logic      busy;
    t_in_item  item;
    logic      strobe;
    t_out_item result;

    int        fail_count;
    int        pending;
    int        items_sent;
    int        idle_cycles;
    bit        steady_feed;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    unique_correspondence_filter DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .o_strobe   (strobe),
        .o_result   (result)
    );

    ucf_pair_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (item),
        .i_strobe    (strobe),
        .i_result    (result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // watchdog: any accepted item or result restarts the count
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("unique_correspondence_filter verification failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one, none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_feed || r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // a small set of distances makes ties and near misses common
    function automatic logic [DIST_BITS-1:0] pick_dist();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'h0001_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item make_pair(input logic [MODEL_BITS-1:0] m,
                                           input logic [SCENE_BITS-1:0] s,
                                           input logic [DIST_BITS-1:0] d);
        t_in_item it;
        it.op          = OP_LOAD;
        it.model_index = m;
        it.scene_index = s;
        it.dist_sqr    = d;
        return it;
    endfunction

    function automatic t_in_item make_load(input logic [MODEL_BITS-1:0] m);
        return make_pair(m, SCENE_BITS'($urandom()), pick_dist());
    endfunction

    // drain item, payload fields carry junk that the block must ignore
    function automatic t_in_item make_drain();
        t_in_item it;
        it    = make_load(MODEL_BITS'($urandom_range(0, 4095)));
        it.op = OP_DRAIN;
        return it;
    endfunction

    // one item: optional gap, then hold start until busy is low at an edge
    task automatic issue(input t_in_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            item  = make_load(MODEL_BITS'($urandom_range(0, 4095)));
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        item  = it;
        do @(posedge clk); while (busy);
        @(negedge clk);
        start = 1'b0;
        items_sent++;
    endtask

    task automatic wait_answers();
        while (pending != 0) @(negedge clk);
    endtask

    // a load into an empty slot answers nothing, so allow its write to finish
    task automatic write_enable(input logic value);
        start = 1'b0;
        wait_answers();
        repeat (8) @(negedge clk);
        while (busy) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // drain one at a time until the block says nothing is left
    task automatic drain_to_empty();
        t_out_item seen;
        int        guard;
        guard = 0;
        do begin
            wait_answers();
            issue(make_drain());
            do @(posedge clk); while (strobe !== 1'b1);
            seen = result;
            @(negedge clk);
            guard++;
        end while (seen.kind == KIND_EMPTY ? 1'b0 : guard < 200);
    endtask

    initial begin
        logic                  use_filter;
        bit                    mid_drain;
        int unsigned           count;
        int unsigned           span;
        logic [MODEL_BITS-1:0] base;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b1;
        start       = 1'b0;
        item        = '0;
        items_sent  = 0;
        steady_feed = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, filtering on from reset
        issue(make_drain());                                   // nothing left yet
        issue(make_pair(12'd0, 16'hFFFF, 32'hFFFF_FFFF));       // empty slot
        issue(make_pair(12'd0, 16'h1234, 32'hFFFF_FFFF));       // tie, new one rejected
        issue(make_pair(12'd0, 16'h0000, 32'h0000_0000));       // nearer, old one out
        issue(make_pair(12'hFFF, 16'hAAAA, 32'h5555_5555));
        issue(make_pair(12'hFFF, 16'h5555, 32'hAAAA_AAAA));     // farther, rejected
        issue(make_pair(12'h800, 16'h8000, 32'h8000_0000));
        issue(make_drain());                                   // slot 0 leaves
        issue(make_pair(12'd0, 16'h0F0F, 32'h0001_0000));       // behind the pointer
        issue(make_drain());
        issue(make_drain());
        issue(make_drain());                                   // nothing left, pointer back
        issue(make_drain());                                   // held pair, marked last
        issue(make_drain());

        // pass-through
        write_enable(1'b0);
        issue(make_pair(12'hFFF, 16'hFFFF, 32'hFFFF_FFFF));
        issue(make_pair(12'd0, 16'h0000, 32'h0000_0000));
        issue(make_pair(12'h555, 16'h5A5A, 32'h0001_0000));
        issue(make_drain());                                   // drains ignore enable

        // random phases: mostly filtered batches drained to empty
        while (items_sent < ITEM_TARGET) begin
            use_filter = ($urandom_range(0, 9) < 7);
            write_enable(use_filter);
            steady_feed = ($urandom_range(0, 4) == 0);
            count = $urandom_range(4, 40);
            base  = MODEL_BITS'($urandom_range(0, 4095));
            span  = $urandom_range(1, 32);
            if (use_filter) begin
                mid_drain = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < count; i++) begin
                    if (mid_drain && i == count / 2) begin
                        repeat ($urandom_range(1, 3)) issue(make_drain());
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        issue(make_load(MODEL_BITS'($urandom_range(0, 4095))));
                    end else begin
                        issue(make_load(MODEL_BITS'(base + $urandom_range(0, span - 1))));
                    end
                end
                // some batches stay in the table for a later phase
                if ($urandom_range(0, 4) != 0) begin
                    drain_to_empty();
                    if (mid_drain) begin
                        drain_to_empty();
                    end
                end
            end else begin
                for (int i = 0; i < count; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        issue(make_drain());
                    end else begin
                        issue(make_load(MODEL_BITS'($urandom_range(0, 4095))));
                    end
                end
            end
        end

        start = 1'b0;
        wait_answers();
        repeat (16) @(negedge clk);
        if (pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("unique_correspondence_filter verification clean");
        end else begin
            $display("unique_correspondence_filter verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ucf_pkg.sv
hdl/ucf_ram.sv
hdl/ucf_ctrl.sv
hdl/unique_correspondence_filter.sv
verif/ucf_pair_checker.sv
verif/unique_correspondence_filter_test.sv
